@@ rtl/cra_pkg.sv @@
// Shared types and command codes for the contiguous ring allocator.
package cra_pkg;

  localparam int LEN_W = 13;
  localparam int OFS_W = 12;

  localparam logic [1:0] CMD_RESERVE = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [LEN_W-1:0] length;
  } cra_in_t;

  typedef struct packed {
    logic             ok;
    logic [OFS_W-1:0] offset;
  } cra_out_t;

endpackage

@@ rtl/contiguous_ring_allocator.sv @@
// Contiguous ring allocator: reserve/release/clear of contiguous regions in a byte ring.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one command per transfer:
//   reserve a length, release a length from the head, or clear to empty.
//   Output channel (out_valid/out_stall/out_data) returns exactly one result per
//   command: ok and, for a successful reserve, the region's start offset.
//   The command is first held in the command register, then it is evaluated against
//   the head, tail and usable-end registers and written to the result register.
//   Throughput is one command per cycle while the receiver does not stall; head,
//   tail and usable end are updated together for each command.
//   While the receiver stalls, the result register holds; one more command is
//   taken into the command register, after which in_stall rises.
//   Reset (rst_n low, synchronous) empties the ring: head and tail at 0 and the
//   usable end at BUFFER_BYTES; no result is pending after reset.
module contiguous_ring_allocator #(
  parameter int BUFFER_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cra_pkg::cra_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cra_pkg::cra_out_t out_data
);
  import cra_pkg::*;

  localparam int PW = $clog2(BUFFER_BYTES + 1);
  localparam int SW = ((PW > LEN_W) ? PW : LEN_W) + 1;
  localparam logic [PW-1:0] BUF_P = PW'(BUFFER_BYTES);
  localparam logic [SW-1:0] BUF_E = SW'(BUFFER_BYTES);

  logic          s1_valid_r;
  cra_in_t       s1_data_r;
  logic          out_valid_r;
  cra_out_t      out_data_r;
  logic [PW-1:0] head_r, tail_r, end_r;
  logic [PW-1:0] head_nxt, tail_nxt, end_nxt;
  cra_out_t      res_nxt;
  logic          advance;

  logic [SW-1:0] head_e, tail_e, end_e, len_e, tl_sum, hd_sum, limit_e, off_e;
  logic          wrapped;

  assign advance   = !(out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    head_e   = SW'(head_r);
    tail_e   = SW'(tail_r);
    end_e    = SW'(end_r);
    len_e    = SW'(s1_data_r.length);
    tl_sum   = tail_e + len_e;
    hd_sum   = head_e + len_e;
    wrapped  = tail_r < head_r;
    limit_e  = wrapped ? end_e : tail_e;
    head_nxt = head_r;
    tail_nxt = tail_r;
    end_nxt  = end_r;
    off_e    = '0;
    res_nxt  = '0;
    case (s1_data_r.cmd)
      CMD_RESERVE: begin
        if (wrapped) begin
          if (tl_sum < head_e) begin
            off_e       = tail_e;
            tail_nxt    = tl_sum[PW-1:0];
            res_nxt.ok  = 1'b1;
          end
        end else if (tl_sum <= end_e) begin
          off_e      = (tail_e < BUF_E) ? tail_e : '0;
          tail_nxt   = tl_sum[PW-1:0];
          res_nxt.ok = 1'b1;
        end else if (len_e < head_e) begin
          end_nxt    = tail_r;
          tail_nxt   = len_e[PW-1:0];
          res_nxt.ok = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (hd_sum <= limit_e) begin
          res_nxt.ok = 1'b1;
          head_nxt   = hd_sum[PW-1:0];
          if (wrapped && hd_sum == end_e) begin
            head_nxt = '0;
            end_nxt  = BUF_P;
          end
          if (head_nxt == tail_r) begin
            head_nxt = '0;
            tail_nxt = '0;
            end_nxt  = BUF_P;
          end
        end
      end
      CMD_CLEAR: begin
        head_nxt   = '0;
        tail_nxt   = '0;
        end_nxt    = BUF_P;
        res_nxt.ok = 1'b1;
      end
      default: begin
      end
    endcase
    res_nxt.offset = off_e[OFS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      end_r       <= BUF_P;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          head_r <= head_nxt;
          tail_r <= tail_nxt;
          end_r  <= end_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  a_end_when_flat: assert property (@(posedge clk) disable iff (!rst_n)
    !(tail_r < head_r) |-> end_r == BUF_P)
    else $error("usable end moved while ring not wrapped");

  a_tail_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= end_r)
    else $error("tail beyond usable end");

  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= end_r)
    else $error("head beyond usable end");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.ok |-> out_data_r.offset == '0)
    else $error("refused command carries nonzero offset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall && s1_valid_r)
    else $error("input stalled without a blocked result");
`endif

endmodule
